FILE: hw/rtl/tlsd_pkg.sv
package tlsd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_PAD     = 3'd3,
    PH_HALT    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_PAD    = 2'd2
  } status_e;

  localparam logic [7:0] BigMarker = 8'd254;
  localparam logic [7:0] BadMarker = 8'd255;
  localparam logic [1:0] LastLenIdx = 2'd2;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       string_end;
    logic [1:0] status;
  } res_t;

endpackage

FILE: hw/rtl/tl_string_deframer_unit.sv
// each result is registered, in the result register or, while the output is stalled, in the skid stage
// throughput: one item per cycle while in_ready_o is high (skid stage empty), one result per item
// a skid stage behind the result register keeps in_ready_o off the out_ready_i path
// reset (rst_ni low, asynchronous): parser waits for a header byte, status ok,
// result and skid stages empty
module tl_string_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic       string_end_o,
  output logic [1:0] status_o
);

  tlsd_pkg::phase_e phase_q, phase_d;
  logic [23:0] bytes_left_q, bytes_left_d;
  logic [1:0]  len_idx_q, len_idx_d;
  logic [1:0]  pad_left_q, pad_left_d;
  logic [1:0]  error_q, error_d;

  logic        accept;
  logic [23:0] len_asm;
  logic [1:0]  long_pad;
  logic [1:0]  short_pad;
  logic [23:0] bytes_dec;
  logic [1:0]  pad_dec;
  tlsd_pkg::res_t res_new;

  logic           out_valid_q, skid_valid_q;
  tlsd_pkg::res_t out_q, skid_q;

  assign in_ready_o = ~skid_valid_q;
  assign accept     = in_valid_i & in_ready_o;

  assign len_asm   = bytes_left_q | ({16'd0, data_byte_i} << {len_idx_q, 3'b000});
  assign long_pad  = 2'd0 - len_asm[1:0];
  assign short_pad = ~data_byte_i[1:0];
  assign bytes_dec = bytes_left_q - 24'd1;
  assign pad_dec   = pad_left_q - 2'd1;

  // next state
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    len_idx_d    = len_idx_q;
    pad_left_d   = pad_left_q;
    error_d      = error_q;
    case (phase_q)
      tlsd_pkg::PH_HEADER: begin
        if (data_byte_i == tlsd_pkg::BadMarker) begin
          error_d = tlsd_pkg::ST_BAD_LENGTH;
          phase_d = tlsd_pkg::PH_HALT;
        end else if (data_byte_i == tlsd_pkg::BigMarker) begin
          bytes_left_d = 24'd0;
          len_idx_d    = 2'd0;
          phase_d      = tlsd_pkg::PH_LENGTH;
        end else begin
          bytes_left_d = {16'd0, data_byte_i};
          pad_left_d   = short_pad;
          phase_d      = (data_byte_i != 8'd0) ? tlsd_pkg::PH_PAYLOAD : tlsd_pkg::PH_PAD;
        end
      end
      tlsd_pkg::PH_LENGTH: begin
        bytes_left_d = len_asm;
        if (len_idx_q >= tlsd_pkg::LastLenIdx) begin
          len_idx_d  = 2'd0;
          pad_left_d = long_pad;
          if (len_asm != 24'd0) begin
            phase_d = tlsd_pkg::PH_PAYLOAD;
          end else if (long_pad != 2'd0) begin
            phase_d = tlsd_pkg::PH_PAD;
          end else begin
            phase_d = tlsd_pkg::PH_HEADER;
          end
        end else begin
          len_idx_d = len_idx_q + 2'd1;
        end
      end
      tlsd_pkg::PH_PAYLOAD: begin
        bytes_left_d = bytes_dec;
        if (bytes_dec == 24'd0) begin
          phase_d = (pad_left_q != 2'd0) ? tlsd_pkg::PH_PAD : tlsd_pkg::PH_HEADER;
        end
      end
      tlsd_pkg::PH_PAD: begin
        if (data_byte_i != 8'd0) begin
          error_d = tlsd_pkg::ST_BAD_PAD;
          phase_d = tlsd_pkg::PH_HALT;
        end else begin
          pad_left_d = pad_dec;
          if (pad_dec == 2'd0) begin
            phase_d = tlsd_pkg::PH_HEADER;
          end
        end
      end
      default: begin
        phase_d = tlsd_pkg::PH_HALT;
      end
    endcase
  end

  // result for the accepted item
  always_comb begin
    res_new.payload_valid = 1'b0;
    res_new.payload_byte  = 8'd0;
    res_new.string_end    = 1'b0;
    res_new.status        = error_d;
    case (phase_q)
      tlsd_pkg::PH_LENGTH: begin
        res_new.string_end = (len_idx_q >= tlsd_pkg::LastLenIdx) &&
                             (len_asm == 24'd0) && (long_pad == 2'd0);
      end
      tlsd_pkg::PH_PAYLOAD: begin
        res_new.payload_valid = 1'b1;
        res_new.payload_byte  = data_byte_i;
        res_new.string_end    = (bytes_dec == 24'd0) && (pad_left_q == 2'd0);
      end
      tlsd_pkg::PH_PAD: begin
        res_new.string_end = (data_byte_i == 8'd0) && (pad_dec == 2'd0);
      end
      default: begin
        res_new.string_end = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= tlsd_pkg::PH_HEADER;
      bytes_left_q <= 24'd0;
      len_idx_q    <= 2'd0;
      pad_left_q   <= 2'd0;
      error_q      <= tlsd_pkg::ST_OK;
    end else if (accept) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      len_idx_q    <= len_idx_d;
      pad_left_q   <= pad_left_d;
      error_q      <= error_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = out_q.payload_valid;
  assign payload_byte_o  = out_q.payload_byte;
  assign string_end_o    = out_q.string_end;
  assign status_o        = out_q.status;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the result register is empty");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tlsd_pkg::PH_HALT) |=> (phase_q == tlsd_pkg::PH_HALT))
    else $error("parser left the halted state");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.payload_valid || out_q.string_end)) |->
      (out_q.status == tlsd_pkg::ST_OK))
    else $error("payload or string end flagged with an error status");

  a_error_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (error_q != tlsd_pkg::ST_OK) |=> $stable(error_q))
    else $error("error status changed after being raised");

endmodule
